@@ rtl/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Shared types, codes and sizes for the command/response engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int FRAME_BYTES   = 6;
    localparam int QUEUE_DEPTH_D = 2;

    // function codes of an input item
    localparam logic FUNC_CMD = 1'b0;
    localparam logic FUNC_RX  = 1'b1;

    // result kinds
    localparam logic OUT_FRAME = 1'b0;
    localparam logic OUT_RESP  = 1'b1;

    // expected response kinds
    localparam logic [2:0] RESP_R1  = 3'd0;
    localparam logic [2:0] RESP_R1B = 3'd1;
    localparam logic [2:0] RESP_R2  = 3'd2;
    localparam logic [2:0] RESP_R3  = 3'd3;
    localparam logic [2:0] RESP_R7  = 3'd4;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NORESP  = 2'd1;
    localparam logic [1:0] ST_INCOMPL = 2'd2;

    localparam logic [7:0]  FILL_BYTE = 8'hFF;
    localparam logic [31:0] FILL_WORD = 32'hFFFF_FFFF;

    // one classified item waiting for the back end
    typedef struct packed {
        logic                           is_cmd;
        logic [2:0]                     kind;
        logic [FRAME_BYTES-1:0][7:0]    frame;
        logic [7:0]                     rx_byte;
        logic                           last;
    } sdspi_entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic         valid;
        sdspi_entry_t entry;
    } sdspi_head_t;

endpackage

@@ rtl/sdspi_if.sv @@
// ----------------------------------------------------------------------------
// SD SPI command engine channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [6:0]  cmd_crc7;
    logic [2:0]  resp_kind;
    logic [7:0]  rx_byte;
    logic        window_last;

    modport source (
        output valid, func, cmd_index, cmd_argument, cmd_crc7, resp_kind,
               rx_byte, window_last,
        input  ready
    );
    modport sink (
        input  valid, func, cmd_index, cmd_argument, cmd_crc7, resp_kind,
               rx_byte, window_last,
        output ready
    );
endinterface

interface sdspi_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [7:0]  r1_status;
    logic [31:0] extra_word;
    logic [1:0]  resp_status;

    modport source (
        output valid, out_kind, tx_byte, tx_last, r1_status, extra_word,
               resp_status,
        input  ready
    );
    modport sink (
        input  valid, out_kind, tx_byte, tx_last, r1_status, extra_word,
               resp_status,
        output ready
    );
endinterface

@@ rtl/sdspi_front.sv @@
// ----------------------------------------------------------------------------
// SD SPI front end
// Accepts input items, classifies them and builds command frames.
// ----------------------------------------------------------------------------
module sdspi_front
    import sdspi_pkg::*;
(
    sdspi_in_if.sink     req,
    input  logic         full,
    output logic         push,
    output sdspi_entry_t push_entry
);

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        push_entry.is_cmd   = (req.func == FUNC_CMD);
        push_entry.kind     = req.resp_kind;
        // frame byte 0 goes first: start bit 0, transmission bit 1, index
        push_entry.frame[0] = {2'b01, req.cmd_index};
        push_entry.frame[1] = req.cmd_argument[31:24];
        push_entry.frame[2] = req.cmd_argument[23:16];
        push_entry.frame[3] = req.cmd_argument[15:8];
        push_entry.frame[4] = req.cmd_argument[7:0];
        push_entry.frame[5] = {req.cmd_crc7, 1'b1};
        push_entry.rx_byte  = req.rx_byte;
        push_entry.last     = req.window_last;
    end

endmodule

@@ rtl/sdspi_queue.sv @@
// ----------------------------------------------------------------------------
// SD SPI item queue
// Short first-in first-out queue between front and back ends.
// ----------------------------------------------------------------------------
module sdspi_queue
    import sdspi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_D
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  sdspi_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output sdspi_head_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    sdspi_entry_t  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/sdspi_back.sv @@
// ----------------------------------------------------------------------------
// SD SPI back end
// Sends frame bytes, runs the response scan and holds the result register.
// ----------------------------------------------------------------------------
module sdspi_back
    import sdspi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sdspi_head_t  head,
    output logic         pop,
    sdspi_out_if.source  res
);

    localparam int BW = $clog2(FRAME_BYTES);
    localparam logic [BW-1:0] LAST_BYTE = BW'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEEK,
        PH_COLLECT,
        PH_DONE
    } phase_t;

    phase_t        phase_reg, phase_next, phase_upd;
    logic [2:0]    kind_reg, kind_next;
    logic [2:0]    need_reg, need_next, need_upd;
    logic [7:0]    r1_reg, r1_next, r1_upd;
    logic [31:0]   pay_reg, pay_next, pay_upd;
    logic [BW-1:0] byte_cnt_reg, byte_cnt_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic [7:0]    tx_byte_reg, tx_byte_next;
    logic          tx_last_reg, tx_last_next;
    logic [7:0]    r1s_reg, r1s_next;
    logic [31:0]   extra_reg, extra_next;
    logic [1:0]    status_reg, status_next;

    logic          out_free;
    logic [2:0]    extra_cnt;
    logic [31:0]   filled;
    sdspi_entry_t  e;

    assign e        = head.entry;
    assign out_free = !out_valid_reg || res.ready;

    // extra bytes that follow R1 for the armed kind
    always_comb
    begin
        unique case (kind_reg)
            RESP_R1B, RESP_R2: extra_cnt = 3'd1;
            RESP_R3, RESP_R7:  extra_cnt = 3'd4;
            default:           extra_cnt = 3'd0;
        endcase
    end

    // scan step for one received byte
    always_comb
    begin
        phase_upd = phase_reg;
        need_upd  = need_reg;
        r1_upd    = r1_reg;
        pay_upd   = pay_reg;
        unique case (phase_reg)
            PH_IDLE, PH_SEEK:
            begin
                if (e.rx_byte != FILL_BYTE)
                begin
                    r1_upd    = e.rx_byte;
                    need_upd  = extra_cnt;
                    pay_upd   = FILL_WORD;
                    phase_upd = (extra_cnt != 3'd0) ? PH_COLLECT : PH_DONE;
                end
                else
                begin
                    phase_upd = PH_SEEK;
                end
            end
            PH_COLLECT:
            begin
                pay_upd  = {pay_reg[23:0], e.rx_byte};
                need_upd = need_reg - 3'd1;
                if (need_reg == 3'd1)
                begin
                    phase_upd = PH_DONE;
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    // pad a cut-off response with filler bytes
    always_comb
    begin
        unique case (need_upd)
            3'd0:    filled = pay_upd;
            3'd1:    filled = {pay_upd[23:0], FILL_BYTE};
            3'd2:    filled = {pay_upd[15:0], FILL_WORD[15:0]};
            3'd3:    filled = {pay_upd[7:0], FILL_WORD[23:0]};
            default: filled = FILL_WORD;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        need_next      = need_reg;
        r1_next        = r1_reg;
        pay_next       = pay_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        tx_byte_next   = tx_byte_reg;
        tx_last_next   = tx_last_reg;
        r1s_next       = r1s_reg;
        extra_next     = extra_reg;
        status_next    = status_reg;
        pop            = 1'b0;

        if (head.valid && e.is_cmd)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = OUT_FRAME;
                tx_byte_next   = e.frame[byte_cnt_reg];
                tx_last_next   = (byte_cnt_reg == LAST_BYTE);
                r1s_next       = '0;
                extra_next     = '0;
                status_next    = ST_OK;
                if (byte_cnt_reg == '0)
                begin
                    // arm a fresh scan for this command
                    kind_next  = e.kind;
                    phase_next = PH_SEEK;
                    need_next  = '0;
                    r1_next    = FILL_BYTE;
                    pay_next   = FILL_WORD;
                end
                if (byte_cnt_reg == LAST_BYTE)
                begin
                    byte_cnt_next = '0;
                    pop           = 1'b1;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                end
            end
        end
        else if (head.valid && (!e.last || out_free))
        begin
            pop        = 1'b1;
            phase_next = phase_upd;
            need_next  = need_upd;
            r1_next    = r1_upd;
            pay_next   = pay_upd;
            if (e.last)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = OUT_RESP;
                tx_byte_next   = '0;
                tx_last_next   = 1'b0;
                if (phase_upd == PH_IDLE || phase_upd == PH_SEEK || kind_reg > RESP_R7)
                begin
                    r1s_next    = FILL_BYTE;
                    extra_next  = FILL_WORD;
                    status_next = ST_NORESP;
                end
                else
                begin
                    r1s_next    = r1_upd;
                    extra_next  = (kind_reg == RESP_R1) ? FILL_WORD : filled;
                    status_next = (phase_upd == PH_COLLECT) ? ST_INCOMPL : ST_OK;
                end
                // drop back to idle after each window
                phase_next = PH_IDLE;
                need_next  = '0;
                r1_next    = FILL_BYTE;
                pay_next   = FILL_WORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= RESP_R1;
            need_reg      <= '0;
            r1_reg        <= FILL_BYTE;
            pay_reg       <= FILL_WORD;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            need_reg      <= need_next;
            r1_reg        <= r1_next;
            pay_reg       <= pay_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        tx_byte_reg  <= tx_byte_next;
        tx_last_reg  <= tx_last_next;
        r1s_reg      <= r1s_next;
        extra_reg    <= extra_next;
        status_reg   <= status_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.out_kind    = out_kind_reg;
    assign res.tx_byte     = tx_byte_reg;
    assign res.tx_last     = tx_last_reg;
    assign res.r1_status   = r1s_reg;
    assign res.extra_word  = extra_reg;
    assign res.resp_status = status_reg;

endmodule

@@ rtl/sd_spi_command_response_engine_unit.sv @@
// An accepted item passes the queue write and then the output register before its result
//   is presented; a stall at the output can hold it in between.
// Throughput: one received byte per cycle, but a window's last byte waits for a free output
//   register; frame bytes go out one by one through the back end's single output register.
// Input stays open while the queue has room, so up to QUEUE_DEPTH - 1 items wait behind a command.
// Reset: rst_n clears the queue, the scan state (idle, kind R1) and the output valid at once.
// ----------------------------------------------------------------------------
// SD SPI command/response engine
// Host side of the SD card SPI command exchange: frames commands and
// assembles R1, R1b, R2, R3 and R7 responses from received bytes.
// ----------------------------------------------------------------------------
module sd_spi_command_response_engine_unit
    import sdspi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
    input  logic        clk,
    input  logic        rst_n,
    sdspi_in_if.sink    req,
    sdspi_out_if.source res
);

    // front to queue
    logic         push;
    sdspi_entry_t push_entry;
    logic         full;

    // queue to back
    logic         pop;
    sdspi_head_t  head;

    // Front: classify each item and build the six frame bytes of a command.
    sdspi_front u_front (
        .req        (req),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouple acceptance from the multi-cycle frame output.
    sdspi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head)
    );

    // Back: emit frame bytes, advance the response scan, hold the result.
    sdspi_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

@@ verif/tb_sd_spi_command_response_engine_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD SPI command/response engine testbench
// Offers command and received-byte items with random gaps and stalls. The
// expected frame bytes and assembled responses come from a local copy of
// the engine's scan logic. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_sd_spi_command_response_engine_unit;
    import sdspi_pkg::*;

    localparam int RANDOM_ITEMS = 224;
    localparam int DIR_ROWS     = 26;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // resp_kind values the engine does not define
    localparam logic [2:0] RESP_UNDEF = 3'd7;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_SEEK, SCAN_COLLECT, SCAN_DONE} scan_phase_t;

    typedef struct packed {
        logic        func;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [6:0]  cmd_crc7;
        logic [2:0]  resp_kind;
        logic [7:0]  rx_byte;
        logic        window_last;
    } spi_req_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [7:0]  r1_status;
        logic [31:0] extra_word;
        logic [1:0]  resp_status;
    } spi_out_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        spi_req_t item;
        logic     typed;
        spi_out_t want;
    } dir_row_t;

    localparam spi_out_t NO_WANT = '0;

    logic clk = 1'b0;
    logic rst_n;

    sdspi_in_if  req_if ();
    sdspi_out_if res_if ();

    sd_spi_command_response_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    // Free-running 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan state mirrored from the engine
    // ------------------------------------------------------------------
    scan_phase_t scan_q   = SCAN_IDLE;
    logic [2:0]  kind_q   = RESP_R1;
    logic [2:0]  need_q   = 3'd0;
    logic [7:0]  r1_q     = FILL_BYTE;
    logic [31:0] shift_q  = FILL_WORD;

    spi_out_t outputs_due[$];

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_request = 1'b0;
    logic hold_sink   = 1'b0;

    int  items_in     = 0;
    int  frames_seen  = 0;
    int  resp_seen    = 0;
    int  status_seen[3];
    int  fail_count   = 0;
    int  cycle_count  = 0;

    // Number of bytes that follow R1 for a response kind
    function automatic int payload_bytes(logic [2:0] kind);
        if (kind == RESP_R1B || kind == RESP_R2)
            return 1;
        if (kind == RESP_R3 || kind == RESP_R7)
            return 4;
        return 0;
    endfunction

    // Work out the frame bytes or the assembled response for one item
    function automatic void frame_and_scan(spi_req_t it);
        logic [7:0]  frame [FRAME_BYTES];
        logic [31:0] fill;
        spi_out_t    res;
        res = '0;
        if (it.func == FUNC_CMD)
        begin
            // start bit 0, transmission bit 1, then index; argument MSB first
            frame[0] = {2'b01, it.cmd_index};
            frame[1] = it.cmd_argument[31:24];
            frame[2] = it.cmd_argument[23:16];
            frame[3] = it.cmd_argument[15:8];
            frame[4] = it.cmd_argument[7:0];
            frame[5] = {it.cmd_crc7, 1'b1};
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                res.out_kind = OUT_FRAME;
                res.tx_byte  = frame[k];
                res.tx_last  = (k == FRAME_BYTES - 1);
                outputs_due.push_back(res);
            end
            // arm a fresh scan; a command in mid-window restarts it
            kind_q  = it.resp_kind;
            scan_q  = SCAN_SEEK;
            need_q  = 3'd0;
            r1_q    = FILL_BYTE;
            shift_q = FILL_WORD;
            return;
        end

        // A byte while idle is scanned with the kind stored last
        if (scan_q == SCAN_IDLE || scan_q == SCAN_SEEK)
        begin
            if (it.rx_byte != FILL_BYTE)
            begin
                r1_q    = it.rx_byte;
                need_q  = 3'(payload_bytes(kind_q));
                shift_q = FILL_WORD;
                scan_q  = (need_q != 0) ? SCAN_COLLECT : SCAN_DONE;
            end
            else
                scan_q = SCAN_SEEK;
        end
        else if (scan_q == SCAN_COLLECT)
        begin
            shift_q = {shift_q[23:0], it.rx_byte};
            need_q  = need_q - 3'd1;
            if (need_q == 0)
                scan_q = SCAN_DONE;
        end
        // bytes after a complete response fall through untouched

        if (!it.window_last)
            return;

        res.out_kind = OUT_RESP;
        if (scan_q == SCAN_IDLE || scan_q == SCAN_SEEK || kind_q > RESP_R7)
        begin
            res.r1_status   = FILL_BYTE;
            res.extra_word  = FILL_WORD;
            res.resp_status = ST_NORESP;
        end
        else
        begin
            // pad a cut-off payload with filler bytes
            fill = shift_q;
            res.resp_status = ST_OK;
            if (scan_q == SCAN_COLLECT)
            begin
                res.resp_status = ST_INCOMPL;
                for (int n = 0; n < need_q; n++)
                    fill = {fill[23:0], FILL_BYTE};
            end
            res.r1_status  = r1_q;
            res.extra_word = (kind_q == RESP_R1) ? FILL_WORD : fill;
        end
        outputs_due.push_back(res);

        scan_q  = SCAN_IDLE;
        need_q  = 3'd0;
        r1_q    = FILL_BYTE;
        shift_q = FILL_WORD;
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle at random, then hold the item until it is taken.
    // Entered and left in the time step of a rising edge.
    // ------------------------------------------------------------------
    task automatic offer(spi_req_t it);
        logic taken;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= it.func;
        req_if.cmd_index    <= it.cmd_index;
        req_if.cmd_argument <= it.cmd_argument;
        req_if.cmd_crc7     <= it.cmd_crc7;
        req_if.resp_kind    <= it.resp_kind;
        req_if.rx_byte      <= it.rx_byte;
        req_if.window_last  <= it.window_last;
        // sample the handshake mid-cycle, where nothing moves
        do
        begin
            @(negedge clk);
            taken = req_if.valid && req_if.ready;
            @(posedge clk);
        end
        while (!taken);
        items_in++;
        frame_and_scan(it);
    endtask

    // A command followed by a plausible card answer with random content
    task automatic send_exchange();
        spi_req_t it;
        spi_req_t window[$];
        int       n_extra;
        int       n_keep;
        logic [2:0] kind;
        it              = '0;
        it.func         = FUNC_CMD;
        it.cmd_index    = 6'($urandom);
        it.cmd_argument = $urandom;
        it.cmd_crc7     = 7'($urandom);
        kind = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
        it.resp_kind = kind;
        offer(it);

        it      = '0;
        it.func = FUNC_RX;
        // leading filler before R1
        repeat ($urandom_range(0, 3))
        begin
            it.rx_byte = FILL_BYTE;
            window.push_back(it);
        end
        // now and then the card stays silent
        if ($urandom_range(9) != 0)
        begin
            it.rx_byte = 8'($urandom_range(0, 254));
            window.push_back(it);
            n_extra = payload_bytes(kind);
            n_keep  = n_extra;
            if (n_extra != 0 && $urandom_range(5) == 0)
                n_keep = $urandom_range(0, n_extra - 1);
            repeat (n_keep)
            begin
                it.rx_byte = 8'($urandom);
                window.push_back(it);
            end
            // trailing bytes only once the response is whole
            if (n_keep == n_extra)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    it.rx_byte = 8'($urandom);
                    window.push_back(it);
                end
            end
        end
        if (window.size() == 0)
        begin
            it.rx_byte = FILL_BYTE;
            window.push_back(it);
        end
        window[window.size() - 1].window_last = 1'b1;
        foreach (window[i])
            offer(window[i]);
    endtask

    // One item with every field random
    task automatic send_noise();
        spi_req_t it;
        it.func         = 1'($urandom);
        it.cmd_index    = 6'($urandom);
        it.cmd_argument = $urandom;
        it.cmd_crc7     = 7'($urandom);
        it.resp_kind    = 3'($urandom);
        it.rx_byte      = 8'($urandom);
        it.window_last  = ($urandom_range(3) == 0);
        offer(it);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
        res_if.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);

    // Hold the output closed long enough for the input queue to fill
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink <= 1'b0;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Check each result against the oldest expectation, mid-cycle
    always @(negedge clk)
    begin : result_check
        spi_out_t got;
        spi_out_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got = '{res_if.out_kind, res_if.tx_byte, res_if.tx_last,
                    res_if.r1_status, res_if.extra_word, res_if.resp_status};
            if (outputs_due.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                fail_count++;
            end
            else
            begin
                want = outputs_due.pop_front();
                check_field("out_kind",    32'(want.out_kind),    32'(got.out_kind));
                check_field("tx_byte",     32'(want.tx_byte),     32'(got.tx_byte));
                check_field("tx_last",     32'(want.tx_last),     32'(got.tx_last));
                check_field("r1_status",   32'(want.r1_status),   32'(got.r1_status));
                check_field("extra_word",  want.extra_word,       got.extra_word);
                check_field("resp_status", 32'(want.resp_status), 32'(got.resp_status));
                if (want.out_kind == OUT_FRAME)
                    frames_seen++;
                else
                begin
                    resp_seen++;
                    if (want.resp_status <= ST_INCOMPL)
                        status_seen[want.resp_status]++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outputs_due.size());
            $display("sd_spi_command_response_engine_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: extremes, every response kind, and the corner cases.
    // Rows with a typed result check against that value; the rest against
    // the predictor.
    // ------------------------------------------------------------------
    dir_row_t directed_rows [DIR_ROWS] = '{
        // filler only, straight after reset: no response
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'hFF, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'hFF, FILL_WORD, ST_NORESP}},
        // byte while idle: scanned as R1 with the reset kind
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h00, FILL_WORD, ST_OK}},
        // all-zero command, R1b
        '{'{FUNC_CMD, 6'd0, 32'h0000_0000, 7'h00, RESP_R1B, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h01, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h01, 32'hFFFF_FF00, ST_OK}},
        // all-ones command, R2, with a byte after the complete response
        '{'{FUNC_CMD, 6'd63, 32'hFFFF_FFFF, 7'h7F, RESP_R2, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h3C, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'hA5, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h77, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h3C, 32'hFFFF_FFA5, ST_OK}},
        // R3 with a filler byte inside the payload
        '{'{FUNC_CMD, 6'd58, 32'h0000_0000, 7'h7E, RESP_R3, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'hC0, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'hFF, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h80, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h00, 32'hC0FF_8000, ST_OK}},
        // R7 cut off after two payload bytes: incomplete
        '{'{FUNC_CMD, 6'd8, 32'h0000_01AA, 7'h43, RESP_R7, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h01, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h01, 32'h0000_FFFF, ST_INCOMPL}},
        // undefined response kind: reported as no response
        '{'{FUNC_CMD, 6'd1, 32'h0000_0000, 7'h00, RESP_UNDEF, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h00, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'hFF, FILL_WORD, ST_NORESP}},
        // second command replaces the first before any byte arrives
        '{'{FUNC_CMD, 6'd12, 32'hDEAD_BEEF, 7'h2A, RESP_R1B, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_CMD, 6'd13, 32'h0000_0000, 7'h00, RESP_R1, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'h05, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'h05, FILL_WORD, ST_OK}},
        // window closes while still seeking R1
        '{'{FUNC_CMD, 6'd55, 32'h8000_0000, 7'h01, RESP_R2, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_RX, 6'd0, 32'd0, 7'd0, RESP_R1, 8'hFF, 1'b1}, 1'b1,
          '{OUT_RESP, 8'h00, 1'b0, 8'hFF, FILL_WORD, ST_NORESP}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // drive every input to a known value from time zero
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.func         <= FUNC_CMD;
        req_if.cmd_index    <= '0;
        req_if.cmd_argument <= '0;
        req_if.cmd_crc7     <= '0;
        req_if.resp_kind    <= RESP_R1;
        req_if.rx_byte      <= '0;
        req_if.window_last  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first phase: sender idles lightly, receiver stalls heavily
        src_idle_pct = 26;
        snk_idle_pct = 76;
        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].item);
            // swap in the hand-written result where one is given
            if (directed_rows[i].typed)
                outputs_due[outputs_due.size() - 1] = directed_rows[i].want;
        end

        while (items_in < DIR_ROWS + RANDOM_ITEMS)
        begin
            if (items_in >= DIR_ROWS + 2 * RANDOM_ITEMS / 3)
            begin
                // last phase: no idling, and one long receiver hold-off
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_request = 1'b1;
            end
            else if (items_in >= DIR_ROWS + RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 76;
                snk_idle_pct = 26;
            end
            if ($urandom_range(99) < 80)
                send_exchange();
            else
                send_noise();
        end
        req_if.valid <= 1'b0;

        // drain, then allow for anything stray to show up
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items in: %0d frame bytes and %0d responses checked",
                 items_in, frames_seen, resp_seen);
        $display("Responses by status: ok %0d, no response %0d, incomplete %0d; %0d errors",
                 status_seen[ST_OK], status_seen[ST_NORESP], status_seen[ST_INCOMPL],
                 fail_count);
        if (fail_count == 0)
            $display("sd_spi_command_response_engine_unit verification clean");
        else
            $display("sd_spi_command_response_engine_unit verification failed");
        $finish;
    end

endmodule

@@ sd_spi_command_response_engine_unit.f @@
rtl/sdspi_pkg.sv
rtl/sdspi_if.sv
rtl/sdspi_front.sv
rtl/sdspi_queue.sv
rtl/sdspi_back.sv
rtl/sd_spi_command_response_engine_unit.sv
verif/tb_sd_spi_command_response_engine_unit.sv
